/* rtl/core/ntpte_pkg.sv */
// ============================================================================
// ntpte_pkg: shared types and constants of the NTP response timestamp extractor
// Packet layout positions, size limits, backoff cap and fixed-point constants.
// ============================================================================
package ntpte_pkg;

	// Packet byte positions (byte counter value while the byte is accepted)
	localparam logic [6:0] POS_LEAP       = 7'd0;
	localparam logic [6:0] POS_STRATUM    = 7'd1;
	localparam logic [6:0] POS_SEC_FIRST  = 7'd40;
	localparam logic [6:0] POS_SEC_LAST   = 7'd43;
	localparam logic [6:0] POS_FRAC_FIRST = 7'd44;
	localparam logic [6:0] POS_FRAC_LAST  = 7'd47;
	localparam logic [6:0] COUNT_MAX      = 7'd127;

	// Accepted packet length range, final byte included
	localparam logic [7:0] MIN_PACKET_BYTES = 8'd48;
	localparam logic [7:0] MAX_PACKET_BYTES = 8'd68;

	localparam logic [31:0] POLL_RESET      = 32'd60000;
	localparam logic [31:0] BACKOFF_CAP     = 32'd300000;
	localparam logic [31:0] SEVENTY_YEARS_S = 32'd2208988800;
	localparam logic [7:0]  STRATUM_MAX     = 8'd15;
	localparam logic [1:0]  LEAP_ALARM      = 2'b11;

	// Fraction units per millisecond: 1000 * FRAC_PER_MS = 2^32 - 296
	localparam logic [22:0] FRAC_PER_MS = 23'd4294967;
	localparam logic [9:0]  MS_PER_S    = 10'd1000;

	// ceil(2^71 / 15625): x * 2^26 / 15625 == (x * ADD_RECIP) >> 45 for x < 2^31
	localparam logic [57:0] ADD_RECIP = 58'd151115727451828647;
	localparam logic [25:0] RECIP_HI  = ADD_RECIP[57:32];
	localparam logic [31:0] RECIP_LO  = ADD_RECIP[31:0];

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_KISS     = 2'd2,
		ST_ZERO_TS  = 2'd3
	} status_t;

	// Timestamp record carried between pipeline stages
	typedef struct packed {
		status_t     status;
		logic        time_valid;
		logic [31:0] seconds;
		logic [31:0] fraction;
		logic [31:0] interval;
		logic [31:0] round_trip;
	} tstamp_t;

	// Final result word
	typedef struct packed {
		status_t     status;
		logic [31:0] ntp_seconds;
		logic [31:0] utc_seconds;
		logic [31:0] fraction;
		logic [9:0]  milliseconds;
		logic        time_valid;
		logic [31:0] interval_ms;
		logic [31:0] round_trip_us;
	} result_t;

endpackage

/* rtl/core/ntpte_capture.sv */
// ============================================================================
// ntpte_capture: packet byte parser and first pipeline stage
// Keeps leap, stratum and transmit timestamp, checks size, kiss-of-death and zero timestamp.
// ============================================================================
module ntpte_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [31:0]         send_time_us,
	input  logic [31:0]         receive_time_us,
	input  logic                cfg_wen,
	input  logic [31:0]         cfg_wdata,
	output logic                meas_valid,
	input  logic                meas_ready,
	output ntpte_pkg::tstamp_t  meas
);

	logic [6:0]  cnt_q;
	logic [1:0]  leap_q, leap_d;
	logic [7:0]  stratum_q, stratum_d;
	logic [31:0] sec_q, sec_d;
	logic [31:0] frac_q, frac_d;
	logic [31:0] interval_q, interval_d;
	logic [32:0] doubled;
	logic [7:0]  length;
	logic        accept;
	logic        valid_d;
	ntpte_pkg::status_t status_d;

	assign accept   = in_valid && in_ready;
	assign in_ready = !meas_valid || meas_ready;

	always_comb begin
		leap_d    = leap_q;
		stratum_d = stratum_q;
		sec_d     = sec_q;
		frac_d    = frac_q;
		if (cnt_q == ntpte_pkg::POS_LEAP) begin
			leap_d = data_byte[7:6];
		end else if (cnt_q == ntpte_pkg::POS_STRATUM) begin
			stratum_d = data_byte;
		end else if (cnt_q >= ntpte_pkg::POS_SEC_FIRST && cnt_q <= ntpte_pkg::POS_SEC_LAST) begin
			sec_d = {sec_q[23:0], data_byte};
		end else if (cnt_q >= ntpte_pkg::POS_FRAC_FIRST
				&& cnt_q <= ntpte_pkg::POS_FRAC_LAST) begin
			frac_d = {frac_q[23:0], data_byte};
		end

		length     = {1'b0, cnt_q} + 8'd1;
		doubled    = {interval_q, 1'b0};
		interval_d = interval_q;
		status_d   = ntpte_pkg::ST_OK;
		if (length < ntpte_pkg::MIN_PACKET_BYTES || length > ntpte_pkg::MAX_PACKET_BYTES) begin
			status_d = ntpte_pkg::ST_BAD_SIZE;
		end else if (stratum_d == 8'd0) begin
			status_d = ntpte_pkg::ST_KISS;
			if (interval_q < ntpte_pkg::BACKOFF_CAP) begin
				interval_d = (doubled > {1'b0, ntpte_pkg::BACKOFF_CAP}) ?
					ntpte_pkg::BACKOFF_CAP : doubled[31:0];
			end
		end else if (sec_d == 32'd0) begin
			status_d = ntpte_pkg::ST_ZERO_TS;
		end

		valid_d = (status_d == ntpte_pkg::ST_OK) && (leap_d != ntpte_pkg::LEAP_ALARM)
			&& (stratum_d != 8'd0) && (stratum_d <= ntpte_pkg::STRATUM_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			leap_q     <= '0;
			stratum_q  <= '0;
			sec_q      <= '0;
			frac_q     <= '0;
			interval_q <= ntpte_pkg::POLL_RESET;
			meas_valid <= 1'b0;
		end else begin
			if (accept) begin
				leap_q    <= leap_d;
				stratum_q <= stratum_d;
				sec_q     <= sec_d;
				frac_q    <= frac_d;
				if (last_byte) begin
					cnt_q <= '0;
				end else if (cnt_q != ntpte_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			if (cfg_wen) begin
				interval_q <= cfg_wdata;
			end else if (accept && last_byte) begin
				interval_q <= interval_d;
			end
			if (in_ready) begin
				meas_valid <= accept && last_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			meas.status     <= status_d;
			meas.time_valid <= valid_d;
			meas.seconds    <= sec_d;
			meas.fraction   <= frac_d;
			meas.interval   <= interval_d;
			meas.round_trip <= receive_time_us - send_time_us;
		end
	end

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (cnt_q == 7'd0))
		else $error("byte count not cleared after final byte");

	a_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte && !cfg_wen && status_d == ntpte_pkg::ST_KISS
			&& interval_q < ntpte_pkg::BACKOFF_CAP)
		|=> (interval_q <= ntpte_pkg::BACKOFF_CAP && interval_q >= $past(interval_q)))
		else $error("kiss-of-death backoff out of range");

endmodule

/* rtl/core/ntpte_delay.sv */
// ============================================================================
// ntpte_delay: half round trip to 32.32 fraction and timestamp compensation
// Three stages: partial products, reciprocal sum, add with carry to seconds.
// ============================================================================
module ntpte_delay (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                meas_valid,
	output logic                meas_ready,
	input  ntpte_pkg::tstamp_t  meas,
	output logic                comp_valid,
	input  logic                comp_ready,
	output ntpte_pkg::tstamp_t  comp
);

	logic               v_s2, v_s3;
	logic               rdy_s2, rdy_s3, rdy_s4;
	logic [30:0]        half;
	logic [56:0]        p_hi_s2;
	logic [62:0]        p_lo_s2;
	ntpte_pkg::tstamp_t meta_s2, meta_s3;
	logic [56:0]        recip_sum;
	logic [43:0]        add_s3;
	logic [44:0]        frac_sum;

	assign rdy_s4     = !comp_valid || comp_ready;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign meas_ready = rdy_s2;

	assign half      = meas.round_trip[31:1];
	// Drop the low 32 bits of the low product, then the remaining 13 of the 45-bit shift
	assign recip_sum = p_hi_s2 + {26'd0, p_lo_s2[62:32]};
	assign frac_sum  = {13'd0, meta_s3.fraction} + {1'b0, add_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			comp_valid <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= meas_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				comp_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && meas_valid) begin
			p_hi_s2 <= {26'd0, half} * {31'd0, ntpte_pkg::RECIP_HI};
			p_lo_s2 <= {32'd0, half} * {31'd0, ntpte_pkg::RECIP_LO};
			meta_s2 <= meas;
		end
		if (rdy_s3 && v_s2) begin
			add_s3  <= recip_sum[56:13];
			meta_s3 <= meta_s2;
		end
		if (rdy_s4 && v_s3) begin
			comp.status     <= meta_s3.status;
			comp.time_valid <= meta_s3.time_valid;
			comp.interval   <= meta_s3.interval;
			comp.round_trip <= meta_s3.round_trip;
			comp.fraction   <= frac_sum[31:0];
			comp.seconds    <= meta_s3.seconds + {19'd0, frac_sum[44:32]};
		end
	end

endmodule

/* rtl/core/ntpte_ms.sv */
// ============================================================================
// ntpte_ms: millisecond conversion, UTC offset and result register
// Estimate by fraction * 1000 >> 32, then correct by one with a compare.
// ============================================================================
module ntpte_ms (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                comp_valid,
	output logic                comp_ready,
	input  ntpte_pkg::tstamp_t  comp,
	output logic                res_valid,
	input  logic                res_ready,
	output ntpte_pkg::result_t  res
);

	logic               v_s5, v_s6;
	logic               rdy_s5, rdy_s6, rdy_s7;
	logic [41:0]        est_prod;
	logic [9:0]         q_s5, q_s6;
	logic [31:0]        utc_s5, utc_s6;
	logic [31:0]        qd_s6;
	ntpte_pkg::tstamp_t meta_s5, meta_s6;
	logic [31:0]        rem;
	logic [9:0]         ms;
	logic               is_ok;

	assign rdy_s7     = !res_valid || res_ready;
	assign rdy_s6     = !v_s6 || rdy_s7;
	assign rdy_s5     = !v_s5 || rdy_s6;
	assign comp_ready = rdy_s5;

	// The estimate is never above the true quotient and at most one below it
	assign est_prod = {10'd0, comp.fraction} * {32'd0, ntpte_pkg::MS_PER_S};
	assign rem      = meta_s6.fraction - qd_s6;
	assign ms       = q_s6 + {9'd0, (rem >= {9'd0, ntpte_pkg::FRAC_PER_MS})};
	assign is_ok    = (meta_s6.status == ntpte_pkg::ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (rdy_s5) begin
				v_s5 <= comp_valid;
			end
			if (rdy_s6) begin
				v_s6 <= v_s5;
			end
			if (rdy_s7) begin
				res_valid <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && comp_valid) begin
			q_s5    <= est_prod[41:32];
			utc_s5  <= comp.seconds - ntpte_pkg::SEVENTY_YEARS_S;
			meta_s5 <= comp;
		end
		if (rdy_s6 && v_s5) begin
			qd_s6   <= {22'd0, q_s5} * {9'd0, ntpte_pkg::FRAC_PER_MS};
			q_s6    <= q_s5;
			utc_s6  <= utc_s5;
			meta_s6 <= meta_s5;
		end
		if (rdy_s7 && v_s6) begin
			res.status        <= meta_s6.status;
			res.interval_ms   <= meta_s6.interval;
			res.ntp_seconds   <= is_ok ? meta_s6.seconds : 32'd0;
			res.utc_seconds   <= is_ok ? utc_s6 : 32'd0;
			res.fraction      <= is_ok ? meta_s6.fraction : 32'd0;
			res.milliseconds  <= is_ok ? ms : 10'd0;
			res.time_valid    <= is_ok && meta_s6.time_valid;
			res.round_trip_us <= is_ok ? meta_s6.round_trip : 32'd0;
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ntpte_pkg::ST_OK)
		|-> (res.ntp_seconds == 32'd0 && res.fraction == 32'd0
			&& res.round_trip_us == 32'd0 && !res.time_valid))
		else $error("failed result carries timestamp data");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.milliseconds <= ntpte_pkg::MS_PER_S))
		else $error("milliseconds out of range");

	a_ms_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ntpte_pkg::ST_OK && res.fraction < {22'd0, ntpte_pkg::MS_PER_S})
		|-> (res.milliseconds == 10'd0))
		else $error("milliseconds inconsistent with fraction");

endmodule

/* rtl/core/ntp_response_timestamp_extract_unit.sv */
// ============================================================================
// ntp_response_timestamp_extract_unit: SNTP response timestamp extractor
// Parses a received NTP response byte stream and reports compensated time.
// ============================================================================
// The block takes one response byte per cycle on the slave stream while
// results are being taken, and then keeps up with a continuous byte stream:
// every cycle can carry a word, including the final byte of one packet
// followed at once by the first byte of the next. Only the final byte
// (tlast) produces a result word on the master stream; the word is
// registered through the capture stage, the delay-compensation path (two
// partial-product multipliers, a reciprocal sum, the 45-bit fraction add
// with carry into the seconds) and the millisecond conversion (an estimate
// multiply, a back-multiply and a correction compare). Each stage holds its
// word only while the next one is full, so input bytes keep flowing while a
// result waits to be taken until the pipeline has filled. The poll interval
// register is written through cfg_wen/cfg_wdata; a write reloads the running
// interval. Write it only while no packet is in flight. A kiss-of-death
// (stratum 0) doubles the running interval up to 300000 ms; bad size, kiss-of-death
// and zero timestamp results carry only status and interval, all other fields zero.
module ntp_response_timestamp_extract_unit (
	input  logic         clk,
	input  logic         arst_n,
	// Response bytes
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // data_byte[7:0], send_time_us[39:8], receive_time_us[71:40]
	input  logic         s_tlast,   // last_byte
	// Results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,   // ntp_seconds[31:0], utc_seconds[63:32], fraction[95:64],
	                                // milliseconds[105:96], time_valid[106], interval_ms[138:107],
	                                // round_trip_us[170:139], zero fill[175:171]
	output logic [1:0]   m_tuser,   // status[1:0]
	// Poll interval register
	input  logic         cfg_wen,
	input  logic [31:0]  cfg_wdata
);

	logic               meas_valid, meas_ready;
	logic               comp_valid, comp_ready;
	ntpte_pkg::tstamp_t meas, comp;
	ntpte_pkg::result_t res;

	// Parse bytes, hold captured fields, check size and stratum
	ntpte_capture u_capture (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.data_byte       (s_tdata[7:0]),
		.last_byte       (s_tlast),
		.send_time_us    (s_tdata[39:8]),
		.receive_time_us (s_tdata[71:40]),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.meas_valid      (meas_valid),
		.meas_ready      (meas_ready),
		.meas            (meas)
	);

	// Advance the timestamp by half the round trip
	ntpte_delay u_delay (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_ready (meas_ready),
		.meas       (meas),
		.comp_valid (comp_valid),
		.comp_ready (comp_ready),
		.comp       (comp)
	);

	// Derive milliseconds and UTC, drop data of failed packets, hold the result
	ntpte_ms u_ms (
		.clk        (clk),
		.arst_n     (arst_n),
		.comp_valid (comp_valid),
		.comp_ready (comp_ready),
		.comp       (comp),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {5'd0, res.round_trip_us, res.interval_ms, res.time_valid,
		res.milliseconds, res.fraction, res.utc_seconds, res.ntp_seconds};

endmodule

/* tb/sv/ntp_timestamp_checker.sv */
// ============================================================================
// ntp_timestamp_checker: result predictor and scoreboard for the extractor
// Watches the byte, result and register channels, predicts each result word
// from the accepted bytes and compares it with what the block delivers.
// ============================================================================
module ntp_timestamp_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [71:0]  s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [175:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         cfg_wen,
	input  logic [31:0]  cfg_wdata,
	output int           mismatches,
	output int           outstanding
);

	localparam logic [31:0] INTERVAL_AT_RESET = 32'd60000;
	localparam logic [31:0] INTERVAL_CAP      = 32'd300000;
	localparam logic [31:0] NTP_TO_UNIX       = 32'd2208988800;
	localparam logic [63:0] MICROS_PER_SEC    = 64'd1000000;
	localparam logic [31:0] UNITS_PER_MS      = 32'd4294967;
	localparam logic [7:0]  LEN_MIN           = 8'd48;
	localparam logic [7:0]  LEN_MAX           = 8'd68;
	localparam logic [6:0]  POS_SATURATED     = 7'd127;

	logic [6:0]         pkt_pos;
	logic [1:0]         leap_ind;
	logic [7:0]         stratum;
	logic [31:0]        ts_seconds;
	logic [31:0]        ts_fraction;
	logic [31:0]        poll_running;
	ntpte_pkg::result_t expected_results[$];
	int                 err_cnt;

	// Absorb one response byte; on the final byte queue the expected result.
	task automatic absorb_byte(input logic [7:0] b, input logic fin,
	                           input logic [31:0] t_tx, input logic [31:0] t_rx);
		logic [6:0]         pos;
		logic [7:0]         len;
		logic [31:0]        half_rt;
		logic [63:0]        add_units;
		logic [63:0]        frac_sum;
		ntpte_pkg::result_t r;
		pos = pkt_pos;
		if (pos == 7'd0) begin
			leap_ind = b[7:6];
		end else if (pos == 7'd1) begin
			stratum = b;
		end else if (pos >= 7'd40 && pos <= 7'd43) begin
			ts_seconds = {ts_seconds[23:0], b};
		end else if (pos >= 7'd44 && pos <= 7'd47) begin
			ts_fraction = {ts_fraction[23:0], b};
		end
		if (pkt_pos != POS_SATURATED)
			pkt_pos = pkt_pos + 7'd1;
		if (!fin)
			return;
		len = {1'b0, pos} + 8'd1;
		pkt_pos = '0;
		r = '0;
		if (len < LEN_MIN || len > LEN_MAX) begin
			r.status = ntpte_pkg::ST_BAD_SIZE;
		end else if (stratum == 8'd0) begin
			r.status = ntpte_pkg::ST_KISS;
			// Double the interval, never beyond the cap
			if (poll_running < INTERVAL_CAP)
				poll_running = (poll_running > (INTERVAL_CAP >> 1)) ? INTERVAL_CAP
				                                                    : poll_running << 1;
		end else if (ts_seconds == 32'd0) begin
			r.status = ntpte_pkg::ST_ZERO_TS;
		end else begin
			r.status        = ntpte_pkg::ST_OK;
			r.round_trip_us = t_rx - t_tx;
			half_rt         = r.round_trip_us >> 1;
			add_units       = {half_rt, 32'd0} / MICROS_PER_SEC;
			frac_sum        = {32'd0, ts_fraction} + add_units;
			r.ntp_seconds   = ts_seconds + frac_sum[63:32];
			r.utc_seconds   = r.ntp_seconds - NTP_TO_UNIX;
			r.fraction      = frac_sum[31:0];
			r.milliseconds  = 10'(r.fraction / UNITS_PER_MS);
			r.time_valid    = (leap_ind != 2'b11) && (stratum >= 8'd1) && (stratum <= 8'd15);
		end
		r.interval_ms = poll_running;
		expected_results.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_pos      = '0;
			leap_ind     = '0;
			stratum      = '0;
			ts_seconds   = '0;
			ts_fraction  = '0;
			poll_running = INTERVAL_AT_RESET;
			expected_results.delete();
			err_cnt      = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					err_cnt++;
					$display("%0t: result word with none expected: status %0h data %0h",
					         $time, m_tuser, m_tdata);
				end else begin
					ntpte_pkg::result_t w;
					w = expected_results.pop_front();
					check_field("status", 32'(w.status), 32'(m_tuser));
					check_field("ntp_seconds", w.ntp_seconds, m_tdata[31:0]);
					check_field("utc_seconds", w.utc_seconds, m_tdata[63:32]);
					check_field("fraction", w.fraction, m_tdata[95:64]);
					check_field("milliseconds", 32'(w.milliseconds), 32'(m_tdata[105:96]));
					check_field("time_valid", 32'(w.time_valid), 32'(m_tdata[106]));
					check_field("interval_ms", w.interval_ms, m_tdata[138:107]);
					check_field("round_trip_us", w.round_trip_us, m_tdata[170:139]);
				end
			end
			if (cfg_wen) begin
				poll_running = cfg_wdata;
			end
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata[7:0], s_tlast, s_tdata[39:8], s_tdata[71:40]);
			mismatches  <= err_cnt;
			outstanding <= expected_results.size();
		end
	end

endmodule

/* tb/sv/ntp_response_timestamp_extract_unit_test.sv */
// ============================================================================
// ntp_response_timestamp_extract_unit_test: stimulus and verdict
// Feeds NTP response packets of every size and content class through the
// extractor under random flow control, rewrites the poll interval between
// phases, and reports the scoreboard result.
// ============================================================================
module ntp_response_timestamp_extract_unit_test;

	// Cycles without any accepted word before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// Quiet cycles after the last result before touching the register or ending
	localparam int SETTLE_CYCLES = 12;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata   = '0;   // data_byte[7:0], send_time_us[39:8], receive_time_us[71:40]
	logic         s_tlast   = 1'b0; // last_byte
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [175:0] m_tdata;          // ntp_seconds, utc_seconds, fraction, milliseconds,
	                                // time_valid, interval_ms, round_trip_us, zero fill
	logic [1:0]   m_tuser;          // status[1:0]
	logic         cfg_wen   = 1'b0;
	logic [31:0]  cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int words_sent;
	int stall_cycles;
	bit steady = 1'b0;

	ntp_response_timestamp_extract_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	ntp_timestamp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Stall the result side at random, never while steady
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 9);
	end

	// Watchdog: count cycles in which neither channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("ntp_response_timestamp_extract_unit_test: errors");
				$finish;
			end
		end
	end

	// Offer one byte, idling at random first; return once the word is taken.
	task automatic put_word(input logic [7:0] b, input logic fin,
	                        input logic [31:0] t_tx, input logic [31:0] t_rx);
		while (!steady && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {t_rx, t_tx, b};
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// Send one response packet; fields outside the kept positions are random.
	task automatic send_packet(input int len, input logic [1:0] leap, input logic [7:0] strat,
	                           input logic [31:0] secs, input logic [31:0] frac,
	                           input logic [31:0] t_tx, input logic [31:0] t_rx);
		logic [7:0] b;
		bit         fin;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 0)
				b[7:6] = leap;
			else if (i == 1)
				b = strat;
			else if (i >= 40 && i <= 43)
				b = secs[8*(43-i) +: 8];
			else if (i >= 44 && i <= 47)
				b = frac[8*(47-i) +: 8];
			fin = (i == len - 1);
			// Times only matter on the final byte; keep them random elsewhere
			if (fin)
				put_word(b, 1'b1, t_tx, t_rx);
			else
				put_word(b, 1'b0, $urandom, $urandom);
		end
	endtask

	// Drop valid, wait for every expected result, then wait out SETTLE_CYCLES.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_poll(input logic [31:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin
		int          kind;
		int          len;
		logic [1:0]  leap;
		logic [7:0]  strat;
		logic [31:0] secs;
		logic [31:0] t_tx;
		logic [31:0] rt;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset interval, every status, field extremes
		send_packet(48, 2'd0, 8'd1, 32'hE000_0000, 32'h0, 32'd1000, 32'd3000);
		// Longest legal packet, alarm leap, top stratum, fraction carry
		send_packet(68, 2'd3, 8'd15, 32'h1234_5678, 32'hFFFF_FFFF, 32'd10, 32'd12);
		send_packet(60, 2'd2, 8'd16, 32'h8000_0001, 32'h8000_0000, 32'd0, 32'd999_999);
		send_packet(50, 2'd1, 8'd255, 32'h0000_0001, 32'h0000_0001, 32'd7, 32'd7);
		// Largest round trip: many whole seconds carried, seconds wrap
		send_packet(48, 2'd0, 8'd2, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0, 32'hFFFF_FFFF);
		// Fraction at the top of the millisecond range
		send_packet(48, 2'd0, 8'd4, 32'hE100_0000, 32'd4294967000, 32'd55, 32'd55);
		// Zero timestamp
		send_packet(48, 2'd0, 8'd5, 32'h0, 32'hFFFF_FFFF, 32'd1, 32'd100);
		// Bad sizes: one short, one long, a lone final byte, counter saturation
		// with stratum 0 so the size check has to win over the backoff
		send_packet(47, 2'd0, 8'd1, 32'hE000_0000, 32'h1, 32'd0, 32'd10);
		send_packet(69, 2'd0, 8'd1, 32'hE000_0000, 32'h1, 32'd0, 32'd10);
		send_packet(1, 2'd0, 8'd0, 32'h0, 32'h0, 32'd0, 32'd0);
		send_packet(130, 2'd0, 8'd0, 32'hE000_0000, 32'h1, 32'd0, 32'd10);
		// Kiss-of-death backoff up to and at the cap; wins over a zero timestamp
		repeat (4) send_packet(48, 2'd0, 8'd0, 32'hE000_0000, 32'h0, 32'd0, 32'd4);
		send_packet(48, 2'd3, 8'd0, 32'h0, 32'h0, 32'd0, 32'd4);
		settle();

		// Zero interval stays zero under backoff
		write_poll(32'd0);
		send_packet(48, 2'd0, 8'd0, 32'hE000_0000, 32'h0, 32'd0, 32'd4);
		send_packet(48, 2'd0, 8'd9, 32'hE000_0000, 32'h0, 32'd0, 32'd4);
		settle();
		// Interval above the cap is left alone
		write_poll(32'hFFFF_FFFF);
		send_packet(48, 2'd0, 8'd0, 32'hE000_0000, 32'h0, 32'd0, 32'd4);
		settle();
		// Just above half the cap: one doubling clips to the cap
		write_poll(32'd150001);
		send_packet(48, 2'd0, 8'd0, 32'hE000_0000, 32'h0, 32'd0, 32'd4);
		settle();
		write_poll(32'd149999);
		send_packet(48, 2'd0, 8'd0, 32'hE000_0000, 32'h0, 32'd0, 32'd4);
		settle();

		// Random: mostly well-formed packets with random content, some broken
		// sizes and pure noise; new interval every third packet
		for (int pkt = 0; pkt < 400 && words_sent < 1450; pkt++) begin
			if (pkt % 3 == 2) begin
				settle();
				case ($urandom_range(3))
					0: write_poll($urandom);
					1: write_poll($urandom_range(300000));
					2: write_poll(32'd300000);
					default: write_poll($urandom_range(1, 1000));
				endcase
			end
			// Long stretch with no idling on either side
			steady = (pkt >= 1 && pkt < 4);
			kind  = $urandom_range(99);
			leap  = ($urandom_range(3) == 0) ? 2'($urandom) : 2'd0;
			strat = ($urandom_range(99) < 85) ? 8'($urandom_range(1, 15)) : 8'($urandom);
			secs  = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
			t_tx  = $urandom;
			rt    = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2000000);
			if (kind < 75)
				len = $urandom_range(48, 68);
			else if (kind < 85)
				len = $urandom_range(1, 47);
			else if (kind < 95)
				len = $urandom_range(69, 130);
			else begin
				// Noise: every field random
				len   = $urandom_range(1, 100);
				leap  = 2'($urandom);
				strat = 8'($urandom);
				secs  = $urandom;
				rt    = $urandom;
			end
			send_packet(len, leap, strat, secs, $urandom, t_tx, t_tx + rt);
		end
		steady = 1'b0;
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("ntp_response_timestamp_extract_unit_test: clean");
		else
			$display("ntp_response_timestamp_extract_unit_test: errors");
		$finish;
	end

endmodule
